[sv/brup_pkg.sv]
`default_nettype none

package brup_pkg;

   // defaults for the top-level parameters
   localparam int RING_DEPTH_DEF   = 64;
   localparam int PACKET_BYTES_DEF = 8;

   localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
   localparam logic [7:0] BYTE_RETURN  = 8'h0D;

   // command kinds decoded by the front end
   typedef enum logic [1:0] {
      OP_PUT    = 2'd0,   // plain byte write
      OP_PUT_NL = 2'd1,   // newline write, carriage return follows
      OP_POLL   = 2'd2    // endpoint ready, drain one packet
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

endpackage

`default_nettype wire

[sv/byte_ring_usb_packetizer.sv]
`default_nettype none

// Byte ring feeding a USB bulk-in endpoint. Each req item is a put (req_tuser 0,
// byte in req_tdata) or a poll (req_tuser 1, data ignored). A put stores the byte
// in a RING_DEPTH ring; a newline gets a carriage return stored after it. Any
// single write into a full ring is dropped, so the ring holds RING_DEPTH-1 bytes
// at most. A poll drains up to PACKET_BYTES bytes as one packet on rsp, one item
// per byte, rsp_tlast on the final one. After a full-size packet that empties the
// ring, the next poll, if the ring is still empty, yields one zero-length item
// (rsp_tuser 1, data 0, tlast 1). A poll with nothing to send yields nothing.
// Puts never yield items. A two-entry command queue decouples the input from
// the engine; an accepted item is registered in the queue and popped once the
// engine is idle. The engine stores a put while idle, a newline put as the newline
// and then the carriage return; a poll of n bytes is decoded, then each packet byte
// goes through a registered ring read and then the output register. A result
// waiting in the output register with rsp_tready low stalls the engine's output
// states; the queue keeps accepting until it holds two.
// The ring contents need no clearing after reset; only bytes written are sent.
module byte_ring_usb_packetizer #(
   parameter int RING_DEPTH   = brup_pkg::RING_DEPTH_DEF,    // 4..256
   parameter int PACKET_BYTES = brup_pkg::PACKET_BYTES_DEF   // 1..64
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,    // [7:0] data_byte
   input  wire        req_tuser,    // [0] req_type: 0 put, 1 poll
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] packet_byte
   output logic       rsp_tuser,    // [0] zero_length
   output logic       rsp_tlast     // last_of_packet
);

   logic              cmd_valid;
   logic              cmd_pop;
   brup_pkg::cmd_type cmd;

   // front: accept and decode into the queue
   brup_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   // back: ring, packet sequencing, result register
   brup_engine #(
      .RING_DEPTH   (RING_DEPTH),
      .PACKET_BYTES (PACKET_BYTES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[sv/brup_front.sv]
`default_nettype none

// Accepts items, decodes their kind and holds them in a two-entry queue.
module brup_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   output logic              req_tready,
   input  wire  [7:0]        req_tdata,    // [7:0] data_byte
   input  wire               req_tuser,    // [0] req_type
   output logic              cmd_valid,
   output brup_pkg::cmd_type cmd,
   input  wire               cmd_pop
);

   brup_pkg::cmd_type q_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        cnt_ff;
   brup_pkg::cmd_type push_cmd;
   logic              push;

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign cmd        = q_ff[rd_ptr_ff];

   always_comb begin
      push_cmd.data = req_tdata;
      if (req_tuser) begin
         push_cmd.op = brup_pkg::OP_POLL;
      end else if (req_tdata == brup_pkg::BYTE_NEWLINE) begin
         push_cmd.op = brup_pkg::OP_PUT_NL;
      end else begin
         push_cmd.op = brup_pkg::OP_PUT;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, cmd_pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cnt_ff != 2'd0)
      else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

[sv/brup_engine.sv]
`default_nettype none

// Back end: ring store, indices, packet sequencer and the result register.
module brup_engine #(
   parameter int RING_DEPTH   = brup_pkg::RING_DEPTH_DEF,
   parameter int PACKET_BYTES = brup_pkg::PACKET_BYTES_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               cmd_valid,
   input  wire brup_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [7:0]        rsp_tdata,    // [7:0] packet_byte
   output logic              rsp_tuser,    // [0] zero_length
   output logic              rsp_tlast     // last_of_packet
);

   localparam int IW = $clog2(RING_DEPTH);
   localparam int CW = IW + 1;
   localparam int PW = $clog2(PACKET_BYTES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUT_CR,
      ST_ZLP,
      ST_RD,
      ST_OUT
   } state_type;

   state_type       state_ff;
   logic [7:0]      mem [RING_DEPTH];
   logic [7:0]      rd_data_ff;
   logic [IW-1:0]   wr_idx_ff;
   logic [IW-1:0]   rd_idx_ff;
   logic            pending_ff;
   logic            full_pkt_ff;
   logic [PW-1:0]   remain_ff;
   logic            out_valid_ff;
   logic [7:0]      out_data_ff;
   logic            out_zl_ff;
   logic            out_last_ff;

   logic [IW-1:0]   wr_next;
   logic [IW-1:0]   rd_next;
   logic            ring_full;
   logic [CW-1:0]   count;
   logic [31:0]     count32;
   logic [PW-1:0]   pkt_len;
   logic            out_free;
   logic            out_load;
   logic            mem_we;
   logic [7:0]      mem_wd;

   assign wr_next   = (wr_idx_ff == IW'(RING_DEPTH - 1)) ? '0 : wr_idx_ff + IW'(1);
   assign rd_next   = (rd_idx_ff == IW'(RING_DEPTH - 1)) ? '0 : rd_idx_ff + IW'(1);
   assign ring_full = (wr_next == rd_idx_ff);

   // bytes held, with the wrap folded in
   assign count   = {1'b0, wr_idx_ff} - {1'b0, rd_idx_ff}
                    + ((wr_idx_ff < rd_idx_ff) ? CW'(RING_DEPTH) : CW'(0));
   assign count32 = 32'(count);
   assign pkt_len = (count32 > 32'(PACKET_BYTES)) ? PW'(PACKET_BYTES) : PW'(count);

   assign out_free = !out_valid_ff || rsp_tready;
   assign out_load = ((state_ff == ST_ZLP) || (state_ff == ST_OUT)) && out_free;
   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;

   always_comb begin
      mem_we = 1'b0;
      mem_wd = cmd.data;
      if (state_ff == ST_PUT_CR) begin
         mem_we = !ring_full;
         mem_wd = brup_pkg::BYTE_RETURN;
      end else if (cmd_pop && (cmd.op != brup_pkg::OP_POLL)) begin
         mem_we = !ring_full;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx_ff] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         pending_ff   <= 1'b0;
         full_pkt_ff  <= 1'b0;
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  case (cmd.op)
                     brup_pkg::OP_PUT, brup_pkg::OP_PUT_NL: begin
                        if (!ring_full) begin
                           wr_idx_ff <= wr_next;
                        end
                        if (cmd.op == brup_pkg::OP_PUT_NL) begin
                           state_ff <= ST_PUT_CR;
                        end
                     end
                     brup_pkg::OP_POLL: begin
                        if (count == '0) begin
                           if (pending_ff) begin
                              state_ff <= ST_ZLP;
                           end
                        end else begin
                           remain_ff   <= pkt_len;
                           full_pkt_ff <= (pkt_len == PW'(PACKET_BYTES));
                           state_ff    <= ST_RD;
                        end
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_PUT_CR: begin
               if (!ring_full) begin
                  wr_idx_ff <= wr_next;
               end
               state_ff <= ST_IDLE;
            end
            ST_ZLP: begin
               if (out_free) begin
                  out_data_ff  <= 8'h00;
                  out_zl_ff    <= 1'b1;
                  out_last_ff  <= 1'b1;
                  pending_ff   <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_RD: begin
               // read data lands in rd_data_ff
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  out_data_ff  <= rd_data_ff;
                  out_zl_ff    <= 1'b0;
                  out_last_ff  <= (remain_ff == PW'(1));
                  rd_idx_ff    <= rd_next;
                  remain_ff    <= remain_ff - PW'(1);
                  if (remain_ff == PW'(1)) begin
                     pending_ff <= full_pkt_ff && (wr_idx_ff == rd_next);
                     state_ff   <= ST_IDLE;
                  end else begin
                     state_ff <= ST_RD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_zl_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   a_rd_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD) |-> (wr_idx_ff != rd_idx_ff))
      else $error("packet read from empty ring");
`endif

`ifndef SYNTHESIS
   a_remain_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD || state_ff == ST_OUT) |-> (remain_ff != '0))
      else $error("byte sequencer ran past packet end");
`endif

`ifndef SYNTHESIS
   a_zlp_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_zl_ff) |-> (out_last_ff && out_data_ff == 8'h00))
      else $error("zero-length item malformed");
`endif

endmodule

`default_nettype wire
